@@ rtl/owm_pkg.sv @@
// ----------------------------------------------------------------------------
// owm_pkg
// Shared constants, codes and controller/datapath interface types of the
// outlier-rejecting window mean.
// ----------------------------------------------------------------------------
package owm_pkg;

  localparam int WINDOW_DEPTH = 40;
  localparam int ANGLE_W      = 8;
  localparam int CMD_W        = 2;
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int IDX_W        = $clog2(WINDOW_DEPTH);
  localparam int SUM_W        = ANGLE_W + CNT_W;
  localparam int SQ_TERM_W    = 2 * ANGLE_W;
  localparam int SQ_W         = SQ_TERM_W + CNT_W;
  localparam int DIV_W        = SQ_W;
  localparam int DCNT_W       = $clog2(DIV_W);

  localparam logic signed [ANGLE_W-1:0] NO_DETECTION = ANGLE_W'(90);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_MEAN  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    DIV_MEAN = 2'd0,
    DIV_VAR  = 2'd1,
    DIV_RES  = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     push;
    logic     clr;
    logic     init;
    logic     rot;
    logic     acc_sum;
    logic     acc_sq;
    logic     walk;
    logic     div_go;
    div_sel_t div_sel;
    logic     emit_empty;
    logic     emit_first;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic idx_last;
    logic div_done;
    logic n_zero;
  } dp_stat_t;

endpackage

@@ rtl/owm_div.sv @@
// ----------------------------------------------------------------------------
// owm_div
// Serial restoring divider: signed dividend by unsigned nonzero divisor,
// one quotient bit per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module owm_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               go,
  input  logic signed [owm_pkg::DIV_W:0]     dividend,
  input  logic        [owm_pkg::CNT_W-1:0]   divisor,
  output logic                               done,
  output logic signed [owm_pkg::DIV_W:0]     quotient
);

  logic                          busy_r;
  logic                          done_r;
  logic [owm_pkg::DCNT_W-1:0]    cnt_r;
  logic [owm_pkg::CNT_W-1:0]     rem_r;
  logic [owm_pkg::DIV_W-1:0]     quo_r;
  logic                          neg_r;

  logic [owm_pkg::DIV_W:0]       neg_dvd;
  logic [owm_pkg::CNT_W:0]       rem_sh;
  logic [owm_pkg::CNT_W:0]       rem_sub;
  logic                          ge;

  assign neg_dvd = -dividend;
  assign rem_sh  = {rem_r, quo_r[owm_pkg::DIV_W-1]};
  assign ge      = (rem_sh >= {1'b0, divisor});
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Shift the dividend out of the top of quo_r while quotient bits enter below.
  always_ff @(posedge clk) begin
    if (go) begin
      cnt_r <= owm_pkg::DCNT_W'(owm_pkg::DIV_W - 1);
      rem_r <= '0;
      neg_r <= dividend[owm_pkg::DIV_W];
      quo_r <= dividend[owm_pkg::DIV_W] ? neg_dvd[owm_pkg::DIV_W-1:0]
                                        : dividend[owm_pkg::DIV_W-1:0];
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      rem_r <= ge ? rem_sub[owm_pkg::CNT_W-1:0] : rem_sh[owm_pkg::CNT_W-1:0];
      quo_r <= {quo_r[owm_pkg::DIV_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

endmodule

@@ rtl/owm_ctrl.sv @@
// ----------------------------------------------------------------------------
// owm_ctrl
// Command decode and sequencing of the three window passes and divisions.
// ----------------------------------------------------------------------------
module owm_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [owm_pkg::CMD_W-1:0]          in_cmd,
  input  logic signed [owm_pkg::ANGLE_W-1:0] in_angle,
  input  owm_pkg::dp_stat_t                  stat,
  output logic                               busy,
  output owm_pkg::dp_cmd_t                   cmd
);

  typedef enum logic [9:0] {
    S_IDLE      = 10'b00_0000_0001,
    S_SUM       = 10'b00_0000_0010,
    S_MEAN_GO   = 10'b00_0000_0100,
    S_MEAN_WAIT = 10'b00_0000_1000,
    S_SQ        = 10'b00_0001_0000,
    S_VAR_GO    = 10'b00_0010_0000,
    S_VAR_WAIT  = 10'b00_0100_0000,
    S_WALK      = 10'b00_1000_0000,
    S_RES_GO    = 10'b01_0000_0000,
    S_RES_WAIT  = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.div_sel = owm_pkg::DIV_MEAN;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (owm_pkg::cmd_t'(in_cmd))
            owm_pkg::CMD_PUSH: begin
              cmd.push = (in_angle != owm_pkg::NO_DETECTION);
            end
            owm_pkg::CMD_MEAN: begin
              if (stat.empty) begin
                cmd.emit_empty = 1'b1;
              end else begin
                cmd.init  = 1'b1;
                state_nxt = S_SUM;
              end
            end
            owm_pkg::CMD_CLEAR: begin
              cmd.clr = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_SUM: begin
        cmd.rot     = 1'b1;
        cmd.acc_sum = 1'b1;
        if (stat.idx_last) state_nxt = S_MEAN_GO;
      end
      S_MEAN_GO: begin
        cmd.div_go = 1'b1;
        state_nxt  = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: begin
        if (stat.div_done) state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.rot    = 1'b1;
        cmd.acc_sq = 1'b1;
        if (stat.idx_last) state_nxt = S_VAR_GO;
      end
      S_VAR_GO: begin
        cmd.div_sel = owm_pkg::DIV_VAR;
        cmd.div_go  = 1'b1;
        state_nxt   = S_VAR_WAIT;
      end
      S_VAR_WAIT: begin
        cmd.div_sel = owm_pkg::DIV_VAR;
        if (stat.div_done) state_nxt = S_WALK;
      end
      S_WALK: begin
        cmd.rot  = 1'b1;
        cmd.walk = 1'b1;
        if (stat.idx_last) state_nxt = S_RES_GO;
      end
      S_RES_GO: begin
        cmd.div_sel = owm_pkg::DIV_RES;
        if (stat.n_zero) begin
          cmd.emit_first = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.div_go = 1'b1;
          state_nxt  = S_RES_WAIT;
        end
      end
      S_RES_WAIT: begin
        cmd.div_sel = owm_pkg::DIV_RES;
        if (stat.div_done) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/owm_dp.sv @@
// ----------------------------------------------------------------------------
// owm_dp
// Sample window shift line, pass accumulators, shared divider and result
// registers.
// ----------------------------------------------------------------------------
module owm_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  owm_pkg::dp_cmd_t                    cmd,
  input  logic signed [owm_pkg::ANGLE_W-1:0]  in_angle,
  output owm_pkg::dp_stat_t                   stat,
  output logic                                out_strobe,
  output logic signed [owm_pkg::ANGLE_W-1:0]  out_mean_angle,
  output logic                                out_empty_res
);

  localparam int D = owm_pkg::WINDOW_DEPTH;

  logic signed [owm_pkg::ANGLE_W-1:0] win_r [D];
  logic [owm_pkg::CNT_W-1:0]          count_r, count_nxt;
  logic [owm_pkg::CNT_W-1:0]          n_r, n_nxt;
  logic [owm_pkg::IDX_W-1:0]          idx_r, idx_nxt;
  logic signed [owm_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  logic [owm_pkg::SQ_W-1:0]           sq_r, sq_nxt;
  logic signed [owm_pkg::ANGLE_W-1:0] m_r;
  logic [owm_pkg::SQ_W-1:0]           q_r;
  logic signed [owm_pkg::ANGLE_W-1:0] first_r;
  logic                               out_strobe_r;
  logic signed [owm_pkg::ANGLE_W-1:0] out_mean_r;
  logic                               out_empty_r;

  logic signed [owm_pkg::ANGLE_W-1:0]   x;
  logic signed [owm_pkg::ANGLE_W:0]     d;
  logic signed [2*owm_pkg::ANGLE_W+1:0] dd_full;
  logic [owm_pkg::SQ_TERM_W-1:0]        dd;
  logic                                 in_range;
  logic                                 outlier;
  logic                                 div_done;
  logic signed [owm_pkg::DIV_W:0]       dividend;
  logic signed [owm_pkg::DIV_W:0]       quotient;

  // The window is read only at its head; the passes rotate it all the way round.
  assign x        = win_r[0];
  assign d        = $signed({x[owm_pkg::ANGLE_W-1], x}) - $signed({m_r[owm_pkg::ANGLE_W-1], m_r});
  assign dd_full  = d * d;
  assign dd       = dd_full[owm_pkg::SQ_TERM_W-1:0];
  assign in_range = (owm_pkg::CNT_W'(idx_r) < n_r);
  assign outlier  = in_range && (owm_pkg::SQ_W'(dd) > q_r);

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      win_r[0] <= in_angle;
      for (int i = 1; i < D; i++) win_r[i] <= win_r[i-1];
    end else if (cmd.rot) begin
      for (int i = 0; i < D - 1; i++) win_r[i] <= win_r[i+1];
      win_r[D-1] <= win_r[0];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.clr) begin
      count_nxt = '0;
    end else if (cmd.push && count_r < owm_pkg::CNT_W'(D)) begin
      count_nxt = count_r + 1'b1;
    end

    idx_nxt = idx_r;
    if (cmd.init) begin
      idx_nxt = '0;
    end else if (cmd.rot) begin
      idx_nxt = (idx_r == owm_pkg::IDX_W'(D - 1)) ? '0 : idx_r + 1'b1;
    end

    sum_nxt = sum_r;
    sq_nxt  = sq_r;
    n_nxt   = n_r;
    if (cmd.init) begin
      sum_nxt = '0;
      sq_nxt  = '0;
      n_nxt   = count_r;
    end else if (cmd.acc_sum && in_range) begin
      sum_nxt = sum_r + owm_pkg::SUM_W'(x);
    end else if (cmd.acc_sq && in_range) begin
      sq_nxt = sq_r + owm_pkg::SQ_W'(dd);
    end else if (cmd.walk && outlier) begin
      // Drop the outlier from both the count and the running sum.
      n_nxt   = n_r - 1'b1;
      sum_nxt = sum_r - owm_pkg::SUM_W'(x);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    sum_r <= sum_nxt;
    sq_r  <= sq_nxt;
    n_r   <= n_nxt;
    if (cmd.init) first_r <= x;
  end

  always_comb begin
    case (cmd.div_sel)
      owm_pkg::DIV_VAR: dividend = $signed({1'b0, sq_r});
      default:          dividend = (owm_pkg::DIV_W+1)'(sum_r);
    endcase
  end

  owm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.div_go),
    .dividend (dividend),
    .divisor  (n_r),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (div_done && cmd.div_sel == owm_pkg::DIV_MEAN) m_r <= quotient[owm_pkg::ANGLE_W-1:0];
    if (div_done && cmd.div_sel == owm_pkg::DIV_VAR)  q_r <= quotient[owm_pkg::SQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit_empty || cmd.emit_first ||
                      (div_done && cmd.div_sel == owm_pkg::DIV_RES);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_empty) begin
      out_mean_r  <= '0;
      out_empty_r <= 1'b1;
    end else if (cmd.emit_first) begin
      out_mean_r  <= first_r;
      out_empty_r <= 1'b0;
    end else if (div_done && cmd.div_sel == owm_pkg::DIV_RES) begin
      out_mean_r  <= quotient[owm_pkg::ANGLE_W-1:0];
      out_empty_r <= 1'b0;
    end
  end

  assign stat.empty    = (count_r == '0);
  assign stat.idx_last = (idx_r == owm_pkg::IDX_W'(D - 1));
  assign stat.div_done = div_done;
  assign stat.n_zero   = (n_r == '0);

  assign out_strobe     = out_strobe_r;
  assign out_mean_angle = out_mean_r;
  assign out_empty_res  = out_empty_r;

endmodule

@@ rtl/outlier_rejecting_window_mean.sv @@
// ----------------------------------------------------------------------------
// outlier_rejecting_window_mean
// Sigma-clipped mean over a newest-first window of signed angle samples.
// ----------------------------------------------------------------------------
// A command is taken at a rising edge where start is high and busy is low.
// Push (angle 90 means no detection and is dropped) and clear give no
// result. Compute on an empty window gives one result (mean 0, empty flag
// set) in the next cycle. Compute on a filled window runs three full
// rotations of the window (sum, squared deviations, outlier walk) and
// three serial divisions of DIV_W bits each, holding busy high throughout;
// when every sample is rejected the last division is skipped. The
// single-port window rotation and the one-bit-per-cycle divider set how
// long busy stays high. The result appears on out_mean_angle/out_empty_res,
// flagged by out_strobe for exactly one cycle; after a filled compute that
// is the same cycle in which busy falls. The receiver cannot stall it, so
// sample it whenever out_strobe is high.
// ----------------------------------------------------------------------------
module outlier_rejecting_window_mean (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [owm_pkg::CMD_W-1:0]           in_cmd,
  input  logic signed [owm_pkg::ANGLE_W-1:0]  in_angle,
  output logic                                out_strobe,
  output logic signed [owm_pkg::ANGLE_W-1:0]  out_mean_angle,
  output logic                                out_empty_res
);

  owm_pkg::dp_cmd_t  dp_cmd;
  owm_pkg::dp_stat_t dp_stat;

  // Sequence the passes: decode commands, then walk sum, variance, outliers.
  owm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_cmd   (in_cmd),
    .in_angle (in_angle),
    .stat     (dp_stat),
    .busy     (busy),
    .cmd      (dp_cmd)
  );

  // Hold the window and accumulators; drive the result beat.
  owm_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (dp_cmd),
    .in_angle       (in_angle),
    .stat           (dp_stat),
    .out_strobe     (out_strobe),
    .out_mean_angle (out_mean_angle),
    .out_empty_res  (out_empty_res)
  );

endmodule

@@ test/window_mean_checker.sv @@
// ----------------------------------------------------------------------------
// window_mean_checker
// Watches the command and result channels of the outlier-rejecting window
// mean, keeps its own copy of the sample window, predicts each clipped mean
// and compares it with the result the block emits.
// ----------------------------------------------------------------------------
module window_mean_checker
  import owm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic [CMD_W-1:0]           in_cmd,
  input  logic signed [ANGLE_W-1:0]  in_angle,
  input  logic                       out_strobe,
  input  logic signed [ANGLE_W-1:0]  out_mean_angle,
  input  logic                       out_empty_res,
  output int                         mismatches,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] mean_angle;
    logic                      empty_res;
  } mean_result_t;

  mean_result_t              expected_means[$];
  logic signed [ANGLE_W-1:0] window_q [WINDOW_DEPTH];
  int                        fill = 0;
  int                        fail_total = 0;

  // Mean of the window after dropping samples whose squared deviation
  // exceeds the integer variance. The walk bound shrinks with n.
  function automatic logic signed [ANGLE_W-1:0] clipped_mean();
    int n, total, sqdev, m, q, res, d, i;
    n     = fill;
    total = 0;
    sqdev = 0;
    for (i = 0; i < n; i++) total += window_q[i];
    m = total / n;
    for (i = 0; i < n; i++) begin
      d = window_q[i] - m;
      sqdev += d * d;
    end
    q   = sqdev / n;
    res = total / n;
    for (i = 0; i < n; i++) begin
      d = window_q[i] - m;
      if (d * d > q) begin
        n--;
        if (n == 0) begin
          res = window_q[0];
        end else begin
          total -= window_q[i];
          res = total / n;
        end
      end
    end
    return ANGLE_W'(res);
  endfunction

  always @(posedge clk) begin
    mean_result_t seen, want;
    cmd_t         cmd;
    if (!rst_n) begin
      foreach (window_q[i]) window_q[i] = '0;
      fill = 0;
      expected_means.delete();
    end else begin
      // check the result first: it belongs to a command taken earlier
      if (out_strobe) begin
        seen.mean_angle = out_mean_angle;
        seen.empty_res  = out_empty_res;
        if (expected_means.size() == 0) begin
          fail_total++;
          if (fail_total <= REPORT_LIMIT)
            $display("%0t: unexpected result: mean_angle %0d empty_res %0b",
                     $time, seen.mean_angle, seen.empty_res);
        end else begin
          want = expected_means.pop_front();
          if (seen != want) begin
            fail_total++;
            if (fail_total <= REPORT_LIMIT)
              $display("%0t: mismatch: mean_angle exp %0d got %0d, empty_res exp %0b got %0b",
                       $time, want.mean_angle, seen.mean_angle, want.empty_res,
                       seen.empty_res);
          end
        end
      end
      if (start && !busy) begin
        cmd = cmd_t'(in_cmd);
        case (cmd)
          CMD_PUSH: begin
            if (in_angle != NO_DETECTION) begin
              for (int i = WINDOW_DEPTH - 1; i > 0; i--) window_q[i] = window_q[i-1];
              window_q[0] = in_angle;
              if (fill < WINDOW_DEPTH) fill++;
            end
          end
          CMD_MEAN: begin
            want.empty_res  = (fill == 0);
            want.mean_angle = (fill == 0) ? '0 : clipped_mean();
            expected_means.push_back(want);
          end
          CMD_CLEAR: begin
            foreach (window_q[i]) window_q[i] = '0;
            fill = 0;
          end
          default: ;
        endcase
      end
    end
    mismatches <= fail_total;
    pending    <= expected_means.size();
  end

endmodule

@@ test/outlier_rejecting_window_mean_tb.sv @@
// ----------------------------------------------------------------------------
// outlier_rejecting_window_mean_tb
// Drives push, compute and clear beats into the outlier-rejecting window
// mean: a directed opening over the corner cases, then random clusters of
// samples with outliers, dropouts and noise, each usually closed by a
// compute. A checker beside the block predicts and compares every result;
// this module only makes stimulus and prints the verdict.
// ----------------------------------------------------------------------------
module outlier_rejecting_window_mean_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import owm_pkg::*;

  // Random beats to send after the directed part; ignored beats do not count.
  localparam int RANDOM_BEATS = 750;
  // Idle cycles to wait at the end, after the last result is back.
  localparam int DRAIN_CYCLES = 300;
  // Even all-compute traffic with long gaps stays far below this.
  localparam int CYCLE_LIMIT  = 1_000_000;

  logic                      clk      = 1'b0;
  logic                      rst_n    = 1'b0;
  logic                      start    = 1'b0;
  logic [CMD_W-1:0]          in_cmd   = CMD_PUSH;
  logic signed [ANGLE_W-1:0] in_angle = '0;
  logic                      busy;
  logic                      out_strobe;
  logic signed [ANGLE_W-1:0] out_mean_angle;
  logic                      out_empty_res;

  int mismatches;
  int pending;
  int cycle_count = 0;
  int beats_sent  = 0;
  int burst_left  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  outlier_rejecting_window_mean dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_angle       (in_angle),
    .out_strobe     (out_strobe),
    .out_mean_angle (out_mean_angle),
    .out_empty_res  (out_empty_res)
  );

  window_mean_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_angle       (in_angle),
    .out_strobe     (out_strobe),
    .out_mean_angle (out_mean_angle),
    .out_empty_res  (out_empty_res),
    .mismatches     (mismatches),
    .pending        (pending)
  );

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Sender pacing. Inside a burst, keep start high so beats go back to back;
  // at the end of a burst drop start for a random gap. Gaps of zero and long
  // bursts give stretches with no idling at all. The result side cannot be
  // stalled, so there is nothing to pace there.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
    gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Present one beat and hold it until an edge where busy is low takes it.
  // Values are read right at the edge, before the block's own updates land.
  task automatic send_beat(input cmd_t cmd, input logic signed [ANGLE_W-1:0] angle);
    in_cmd   <= cmd;
    in_angle <= angle;
    start    <= 1'b1;
    do @(posedge clk); while (busy);
    // no-detection pushes and the unused command are dropped by the block
    if (cmd != CMD_NONE && !(cmd == CMD_PUSH && angle == NO_DETECTION)) beats_sent++;
    pace();
  endtask

  // One random episode. Most are well formed: maybe a clear, then a cluster
  // of pushes around a random center with some wild outliers, dropouts and
  // out-of-range codes mixed in, then usually a compute. A few are pure noise
  // over every command code and every angle bit.
  task automatic send_episode();
    int center, spread, len, roll, a;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      repeat ($urandom_range(1, 6)) send_beat(cmd_t'($urandom_range(0, 3)), ANGLE_W'($urandom));
      return;
    end
    if (roll < 16) send_beat(CMD_CLEAR, ANGLE_W'($urandom));
    center = int'($urandom_range(0, 170)) - 85;
    spread = $urandom_range(0, 15);
    // mostly short windows; now and then overfill to hit saturation
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 50) : $urandom_range(1, 12);
    repeat (len) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        a = int'($urandom_range(0, 180)) - 90;
      end else if (roll < 14) begin
        a = NO_DETECTION;
      end else if (roll < 17) begin
        a = int'($urandom_range(0, 255)) - 128;
      end else begin
        a = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (a > 89) a = 89;
        if (a < -90) a = -90;
      end
      send_beat(CMD_PUSH, ANGLE_W'(a));
    end
    roll = $urandom_range(0, 99);
    if (roll >= 15) send_beat(CMD_MEAN, ANGLE_W'($urandom));
    if (roll >= 85) send_beat(CMD_MEAN, ANGLE_W'($urandom));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening.
    send_beat(CMD_MEAN, 8'sd0);        // empty window: zero with the empty flag
    send_beat(CMD_PUSH, NO_DETECTION); // no detection: dropped
    send_beat(CMD_MEAN, 8'sd0);        // still empty
    send_beat(CMD_NONE, 8'sh55);       // unused command: no effect
    send_beat(CMD_PUSH, 8'sh80);       // out-of-range codes are stored as given
    send_beat(CMD_PUSH, 8'sd127);
    send_beat(CMD_MEAN, 8'sd0);
    send_beat(CMD_CLEAR, 8'sd0);
    send_beat(CMD_MEAN, -8'sd1);       // empty again after clear
    send_beat(CMD_PUSH, -8'sd1);
    send_beat(CMD_PUSH, -8'sd2);
    send_beat(CMD_MEAN, 8'sd0);        // negative mean truncates toward zero
    send_beat(CMD_CLEAR, 8'sd0);
    send_beat(CMD_PUSH, 8'sd10);
    send_beat(CMD_PUSH, 8'sd10);
    send_beat(CMD_PUSH, 8'sd10);
    send_beat(CMD_PUSH, 8'sd60);       // newest sample is an outlier
    send_beat(CMD_MEAN, 8'sd0);
    send_beat(CMD_PUSH, 8'sd89);
    send_beat(CMD_PUSH, -8'sd90);
    send_beat(CMD_MEAN, 8'sd0);
    send_beat(CMD_CLEAR, 8'sd0);
    send_beat(CMD_PUSH, 8'sd7);
    send_beat(CMD_MEAN, 8'sd0);        // single sample
    send_beat(CMD_NONE, -8'sd1);

    // Random part.
    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) send_episode();
    start <= 1'b0;

    // Drain: let every compute come back, then idle past the block's latency.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
